// ===== rtl/core/srtq_pkg.sv =====
package srtq_pkg;

	localparam int ID_W   = 6;
	localparam int TIME_W = 64;

	localparam logic [1:0] MODE_ENQ = 2'd0;
	localparam logic [1:0] MODE_REM = 2'd1;
	localparam logic [1:0] MODE_DEQ = 2'd2;

	typedef struct packed {
		logic [1:0]        mode;
		logic [ID_W-1:0]   thread_id;
		logic [TIME_W-1:0] release_time;
	} cmd_t;

	typedef struct packed {
		logic [ID_W-1:0] popped_thread;
		logic            popped_valid;
		logic            reprogram;
		logic            status;
		logic [ID_W-1:0] head_thread;
		logic            head_valid;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_INS_SELF,
		ST_INS_NBR,
		ST_RM_DATA,
		ST_RM_FIX,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/core/sorted_release_time_queue.sv =====
// Release-time ordered thread queue (earliest release first, FIFO among ties).
// Command channel cmd/cmd_valid/cmd_stall carries one transaction per request:
// enqueue a thread with its release time, remove a thread, or dequeue the head.
// Each command yields exactly one result transaction on res/res_valid/res_stall,
// giving the popped thread, reprogram (head changed), status (1 = ignored, but 0
// for a remove of an unqueued thread) and the head after the operation.
// Commands are handled one at a time; cmd_stall is high while one is in flight.
// On the way to the result: an ignored or no-op command goes straight to done,
// remove/dequeue of the head passes ST_RM_DATA, other removes ST_RM_DATA and
// ST_RM_FIX, enqueue a walk from the head (up to THREADS - 1 entries) and then
// ST_INS_SELF and ST_INS_NBR. The walk reads one list entry per cycle from the
// time/next RAM. The next command is accepted the cycle after its result is
// loaded.
// Reset clears the head pointer and all queued flags, so the queue is empty
// immediately; the link and time RAMs need no clearing.
// The result sits in an output register; a stalled result holds there and the
// next command is still taken, but its result waits until the slot frees.
module sorted_release_time_queue #(
	parameter int THREADS = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_stall,
	input  srtq_pkg::cmd_t  cmd,
	output logic            res_valid,
	input  logic            res_stall,
	output srtq_pkg::res_t  res
);

	localparam int IW = $clog2(THREADS);
	localparam int LW = $clog2(THREADS + 1);
	localparam int AW = srtq_pkg::TIME_W + LW;
	localparam logic [LW-1:0] NIL = LW'(THREADS);

	srtq_pkg::state_t state_q, state_d;

	logic [IW-1:0]               head_q;
	logic                        head_present_q;
	logic [THREADS-1:0]          queued_q;
	logic [IW-1:0]               t_q;
	logic [IW-1:0]               cur_q;
	logic [LW-1:0]               before_q;
	logic [LW-1:0]               after_q;
	logic [srtq_pkg::TIME_W-1:0] when_q;
	logic [srtq_pkg::TIME_W-1:0] before_time_q;
	logic [srtq_pkg::ID_W-1:0]   popped_q;
	logic                        popped_valid_q;
	logic                        reprogram_q;
	logic                        status_q;
	logic                        res_valid_q;
	srtq_pkg::res_t              res_q;

	// RAM A: {release time, next link}; RAM B: prev link
	logic          a_we, b_we;
	logic [IW-1:0] a_waddr, b_waddr, a_raddr, b_raddr;
	logic [AW-1:0] a_wdata, a_rdata;
	logic [LW-1:0] b_wdata, b_rdata;

	logic [srtq_pkg::TIME_W-1:0] a_time;
	logic [LW-1:0]               a_next;

	logic          cmd_fire;
	logic          tid_ok;
	logic [IW-1:0] tid_idx;
	logic          tid_queued;
	logic          walk_adv;
	logic          res_load;

	assign a_time = a_rdata[AW-1:LW];
	assign a_next = a_rdata[LW-1:0];

	assign cmd_stall  = (state_q != srtq_pkg::ST_IDLE);
	assign cmd_fire   = cmd_valid && !cmd_stall;
	assign tid_ok     = {26'd0, cmd.thread_id} < 32'(THREADS);
	assign tid_idx    = IW'(cmd.thread_id);
	assign tid_queued = queued_q[tid_idx];
	assign walk_adv   = (when_q >= a_time);
	assign res_load   = (state_q == srtq_pkg::ST_DONE) && (!res_valid_q || !res_stall);

	srtq_ram #(.WIDTH(AW), .DEPTH(THREADS)) u_time_next_ram (
		.clk   (clk),
		.we    (a_we),
		.waddr (a_waddr),
		.wdata (a_wdata),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	srtq_ram #(.WIDTH(LW), .DEPTH(THREADS)) u_prev_ram (
		.clk   (clk),
		.we    (b_we),
		.waddr (b_waddr),
		.wdata (b_wdata),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srtq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		a_we    = 1'b0;
		a_waddr = t_q;
		a_wdata = {when_q, after_q};
		a_raddr = head_q;
		b_we    = 1'b0;
		b_waddr = t_q;
		b_wdata = before_q;
		b_raddr = tid_idx;
		unique case (state_q)
			srtq_pkg::ST_IDLE: begin
				if (cmd_fire) begin
					state_d = srtq_pkg::ST_DONE;
					case (cmd.mode)
						srtq_pkg::MODE_ENQ: begin
							if (tid_ok && !tid_queued) begin
								state_d = head_present_q ? srtq_pkg::ST_WALK
								                         : srtq_pkg::ST_INS_SELF;
							end
						end
						srtq_pkg::MODE_REM: begin
							a_raddr = tid_idx;
							if (tid_ok && tid_queued) begin
								state_d = srtq_pkg::ST_RM_DATA;
							end
						end
						srtq_pkg::MODE_DEQ: begin
							b_raddr = head_q;
							if (head_present_q) begin
								state_d = srtq_pkg::ST_RM_DATA;
							end
						end
						default: ;
					endcase
				end
			end
			srtq_pkg::ST_WALK: begin
				a_raddr = a_next[IW-1:0];
				if (!walk_adv || a_next == NIL) begin
					state_d = srtq_pkg::ST_INS_SELF;
				end
			end
			srtq_pkg::ST_INS_SELF: begin
				a_we    = 1'b1;
				b_we    = 1'b1;
				state_d = srtq_pkg::ST_INS_NBR;
			end
			srtq_pkg::ST_INS_NBR: begin
				a_we    = (before_q != NIL);
				a_waddr = before_q[IW-1:0];
				a_wdata = {before_time_q, LW'(t_q)};
				b_we    = (after_q != NIL);
				b_waddr = after_q[IW-1:0];
				b_wdata = LW'(t_q);
				state_d = srtq_pkg::ST_DONE;
			end
			srtq_pkg::ST_RM_DATA: begin
				// unlink: prev[n] = p now, next[p] = n after reading p's time
				b_we    = (a_next != NIL);
				b_waddr = a_next[IW-1:0];
				b_wdata = b_rdata;
				a_raddr = b_rdata[IW-1:0];
				state_d = (b_rdata != NIL) ? srtq_pkg::ST_RM_FIX : srtq_pkg::ST_DONE;
			end
			srtq_pkg::ST_RM_FIX: begin
				a_we    = 1'b1;
				a_waddr = before_q[IW-1:0];
				a_wdata = {a_time, after_q};
				state_d = srtq_pkg::ST_DONE;
			end
			srtq_pkg::ST_DONE: begin
				if (res_load) begin
					state_d = srtq_pkg::ST_IDLE;
				end
			end
			default: state_d = srtq_pkg::ST_IDLE;
		endcase
	end

	// queue head and membership
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q         <= '0;
			head_present_q <= 1'b0;
			queued_q       <= '0;
		end else begin
			case (state_q)
				srtq_pkg::ST_INS_SELF: begin
					queued_q[t_q] <= 1'b1;
					if (before_q == NIL) begin
						head_q         <= t_q;
						head_present_q <= 1'b1;
					end
				end
				srtq_pkg::ST_RM_DATA: begin
					queued_q[t_q] <= 1'b0;
					if (b_rdata == NIL) begin
						head_q         <= (a_next != NIL) ? a_next[IW-1:0] : '0;
						head_present_q <= (a_next != NIL);
					end
				end
				default: ;
			endcase
		end
	end

	// per-command working registers
	always_ff @(posedge clk) begin
		case (state_q)
			srtq_pkg::ST_IDLE: begin
				if (cmd_fire) begin
					t_q            <= tid_idx;
					when_q         <= cmd.release_time;
					cur_q          <= head_q;
					before_q       <= NIL;
					after_q        <= NIL;
					popped_q       <= '0;
					popped_valid_q <= 1'b0;
					reprogram_q    <= 1'b0;
					status_q       <= 1'b0;
					case (cmd.mode)
						srtq_pkg::MODE_ENQ: begin
							status_q <= !tid_ok || tid_queued;
						end
						srtq_pkg::MODE_REM: begin
							status_q <= !tid_ok;
						end
						srtq_pkg::MODE_DEQ: begin
							t_q <= head_q;
							if (head_present_q) begin
								popped_q       <= srtq_pkg::ID_W'(head_q);
								popped_valid_q <= 1'b1;
								reprogram_q    <= 1'b1;
							end else begin
								status_q <= 1'b1;
							end
						end
						default: status_q <= 1'b1;
					endcase
				end
			end
			srtq_pkg::ST_WALK: begin
				if (walk_adv) begin
					before_q      <= LW'(cur_q);
					before_time_q <= a_time;
					cur_q         <= a_next[IW-1:0];
					if (a_next == NIL) begin
						after_q <= NIL;
					end
				end else begin
					after_q <= LW'(cur_q);
				end
			end
			srtq_pkg::ST_INS_SELF: begin
				if (before_q == NIL) begin
					reprogram_q <= 1'b1;
				end
			end
			srtq_pkg::ST_RM_DATA: begin
				before_q <= b_rdata;
				after_q  <= a_next;
				if (b_rdata == NIL) begin
					reprogram_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q.popped_thread <= popped_q;
			res_q.popped_valid  <= popped_valid_q;
			res_q.reprogram     <= reprogram_q;
			res_q.status        <= status_q;
			res_q.head_thread   <= head_present_q ? srtq_pkg::ID_W'(head_q) : '0;
			res_q.head_valid    <= head_present_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== rtl/core/srtq_ram.sv =====
module srtq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== tb/tb_sorted_release_time_queue.sv =====
module tb_sorted_release_time_queue;

	localparam int         N_THREADS  = 64;
	localparam logic [6:0] NO_LINK    = 7'd64;
	localparam logic [1:0] MODE_NOP   = 2'd3;
	localparam int         N_RANDOM   = 600;
	localparam int         IDLE_LIMIT = 4000;
	localparam int         HOLD_LEN   = 400;
	localparam int         TAIL_WAIT  = 100;

	logic            clk       = 1'b0;
	logic            arst_n    = 1'b0;
	logic            cmd_valid = 1'b0;
	logic            cmd_stall;
	srtq_pkg::cmd_t  cmd       = '0;
	logic            res_valid;
	logic            res_stall = 1'b0;
	srtq_pkg::res_t  res;

	sorted_release_time_queue #(.THREADS(N_THREADS)) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always #5 clk = ~clk;

	// shadow of the linked list
	logic [5:0]  head_id;
	logic        head_ok;
	logic [6:0]  nxt     [N_THREADS];
	logic [6:0]  prv     [N_THREADS];
	logic        in_list [N_THREADS];
	logic [63:0] rel_time[N_THREADS];

	srtq_pkg::cmd_t cmd_backlog[$];
	srtq_pkg::res_t outcome_q[$];

	int n_total;
	int n_taken  = 0;
	int n_results = 0;
	int n_errors = 0;
	int burst_left, gap_left;
	int stall_pct, pat_left, hold_left, holds_done;
	int idle_cycles = 0;
	logic draining = 1'b0;

	task automatic report_error(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		n_errors++;
	endtask

	function automatic logic unlink(input logic [5:0] t);
		logic [6:0] p, n;
		logic moved;
		p = prv[t];
		n = nxt[t];
		moved = 1'b0;
		if (p != NO_LINK) begin
			nxt[p[5:0]] = n;
		end else begin
			head_id = (n != NO_LINK) ? n[5:0] : '0;
			head_ok = (n != NO_LINK);
			moved = 1'b1;
		end
		if (n != NO_LINK)
			prv[n[5:0]] = p;
		nxt[t] = NO_LINK;
		prv[t] = NO_LINK;
		in_list[t] = 1'b0;
		return moved;
	endfunction

	task automatic run_queue_op(input srtq_pkg::cmd_t c);
		srtq_pkg::res_t r;
		logic [6:0] bf, af;
		int steps;
		logic [5:0] t;
		r = '0;
		t = c.thread_id;
		case (c.mode)
			srtq_pkg::MODE_ENQ: begin
				if (in_list[t]) begin
					r.status = 1'b1;
				end else begin
					// walk past every entry with time <= ours so ties stay FIFO
					bf = NO_LINK;
					af = head_ok ? {1'b0, head_id} : NO_LINK;
					steps = 0;
					while (af != NO_LINK && steps < N_THREADS &&
							c.release_time >= rel_time[af[5:0]]) begin
						bf = af;
						af = nxt[af[5:0]];
						steps++;
					end
					if (bf == NO_LINK) begin
						head_id = t;
						head_ok = 1'b1;
						r.reprogram = 1'b1;
					end else begin
						nxt[bf[5:0]] = {1'b0, t};
					end
					if (af != NO_LINK)
						prv[af[5:0]] = {1'b0, t};
					nxt[t] = af;
					prv[t] = bf;
					rel_time[t] = c.release_time;
					in_list[t] = 1'b1;
				end
			end
			srtq_pkg::MODE_REM: begin
				if (in_list[t])
					r.reprogram = unlink(t);
			end
			srtq_pkg::MODE_DEQ: begin
				if (!head_ok) begin
					r.status = 1'b1;
				end else begin
					r.popped_thread = head_id;
					r.popped_valid = 1'b1;
					r.reprogram = 1'b1;
					void'(unlink(head_id));
				end
			end
			default: begin
				r.status = 1'b1;
			end
		endcase
		r.head_thread = head_ok ? head_id : '0;
		r.head_valid = head_ok;
		outcome_q.push_back(r);
	endtask

	task automatic add_cmd(input logic [1:0] m, input logic [5:0] id, input logic [63:0] rt);
		srtq_pkg::cmd_t c;
		c.mode = m;
		c.thread_id = id;
		c.release_time = rt;
		cmd_backlog.push_back(c);
	endtask

	function automatic logic [63:0] pick_time();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return 64'($urandom_range(0, 15));
			5, 6, 7: return {$urandom, $urandom};
			8: return $urandom_range(0, 1) ? '1 : '0;
			default: return 64'(1000 + $urandom_range(0, 3));
		endcase
	endfunction

	task automatic compare_field(input string name, input logic [5:0] got,
			input logic [5:0] want);
		if (got !== want)
			report_error($sformatf("result %0d %s: got %0d, want %0d",
				n_results, name, got, want));
	endtask

	// command driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd <= '0;
			burst_left = 1;
			gap_left = 0;
			head_id = '0;
			head_ok = 1'b0;
			for (int i = 0; i < N_THREADS; i++)
				in_list[i] = 1'b0;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				run_queue_op(cmd);
				n_taken <= n_taken + 1;
			end
			if (!(cmd_valid && cmd_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					cmd_valid <= 1'b0;
				end else if (cmd_backlog.size() > 0) begin
					cmd <= cmd_backlog.pop_front();
					cmd_valid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 30);
						case ($urandom_range(0, 3))
							0: gap_left = 0;
							1, 2: gap_left = $urandom_range(1, 6);
							default: gap_left = $urandom_range(10, 80);
						endcase
					end
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			stall_pct = 0;
			pat_left = 0;
			hold_left = 0;
			holds_done = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (outcome_q.size() == 0) begin
					report_error($sformatf("result %0d arrived with none pending", n_results));
				end else begin
					srtq_pkg::res_t want;
					want = outcome_q.pop_front();
					compare_field("popped_thread", res.popped_thread, want.popped_thread);
					compare_field("popped_valid", 6'(res.popped_valid),
						6'(want.popped_valid));
					compare_field("reprogram", 6'(res.reprogram), 6'(want.reprogram));
					compare_field("status", 6'(res.status), 6'(want.status));
					compare_field("head_thread", res.head_thread, want.head_thread);
					compare_field("head_valid", 6'(res.head_valid), 6'(want.head_valid));
				end
				n_results++;
			end
			// long hold-off lets the block back up into the command side
			if (holds_done < 2 && n_results >= 150 * (holds_done + 1)) begin
				hold_left = HOLD_LEN;
				holds_done++;
			end
			if (draining) begin
				res_stall <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else begin
				if (pat_left == 0) begin
					case ($urandom_range(0, 3))
						0: stall_pct = 0;
						1: stall_pct = 20;
						2: stall_pct = 50;
						default: stall_pct = 85;
					endcase
					pat_left = $urandom_range(20, 80);
				end else begin
					pat_left--;
				end
				res_stall <= ($urandom_range(0, 99) < stall_pct);
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		int phase, r;
		logic [1:0] m;

		// directed: empty queue, no-op, ties, extremes, head/middle/tail removal
		add_cmd(srtq_pkg::MODE_DEQ, 6'd0, '0);
		add_cmd(MODE_NOP, 6'd0, '0);
		add_cmd(srtq_pkg::MODE_REM, 6'd9, '0);
		add_cmd(srtq_pkg::MODE_ENQ, 6'd0, '0);
		add_cmd(srtq_pkg::MODE_ENQ, 6'd63, '1);
		add_cmd(srtq_pkg::MODE_ENQ, 6'd5, '0);
		add_cmd(srtq_pkg::MODE_ENQ, 6'd0, 64'd5);
		add_cmd(srtq_pkg::MODE_ENQ, 6'd42, 64'h8000_0000_0000_0000);
		add_cmd(srtq_pkg::MODE_ENQ, 6'd21, 64'h7FFF_FFFF_FFFF_FFFF);
		add_cmd(srtq_pkg::MODE_REM, 6'd5, '0);
		add_cmd(srtq_pkg::MODE_REM, 6'd0, '0);
		add_cmd(srtq_pkg::MODE_ENQ, 6'd7, 64'd1);
		add_cmd(srtq_pkg::MODE_DEQ, 6'd33, '1);
		add_cmd(srtq_pkg::MODE_REM, 6'd63, '0);
		add_cmd(srtq_pkg::MODE_DEQ, 6'd0, '0);
		add_cmd(srtq_pkg::MODE_DEQ, 6'd0, '0);
		add_cmd(srtq_pkg::MODE_DEQ, 6'd0, '0);
		add_cmd(MODE_NOP, 6'd63, '1);
		add_cmd(srtq_pkg::MODE_ENQ, 6'd63, '1);
		add_cmd(srtq_pkg::MODE_ENQ, 6'd1, '1);
		add_cmd(srtq_pkg::MODE_REM, 6'd1, '0);
		add_cmd(srtq_pkg::MODE_DEQ, 6'd0, '0);

		// random: fill, mixed and drain phases so list depth swings widely
		for (int i = 0; i < N_RANDOM; i++) begin
			phase = (i / 75) % 3;
			r = $urandom_range(0, 99);
			if (r < 3)
				m = MODE_NOP;
			else if (phase == 0)
				m = (r < 85) ? srtq_pkg::MODE_ENQ :
					(r < 93) ? srtq_pkg::MODE_REM : srtq_pkg::MODE_DEQ;
			else if (phase == 1)
				m = (r < 50) ? srtq_pkg::MODE_ENQ :
					(r < 75) ? srtq_pkg::MODE_REM : srtq_pkg::MODE_DEQ;
			else
				m = (r < 20) ? srtq_pkg::MODE_ENQ :
					(r < 45) ? srtq_pkg::MODE_REM : srtq_pkg::MODE_DEQ;
			add_cmd(m, 6'($urandom_range(0, 63)), pick_time());
		end
		n_total = cmd_backlog.size();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (n_taken < n_total) @(posedge clk);
		while (outcome_q.size() != 0) @(posedge clk);
		draining <= 1'b1;
		repeat (TAIL_WAIT) @(posedge clk);

		if (n_errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/srtq_pkg.sv
rtl/core/srtq_ram.sv
rtl/core/sorted_release_time_queue.sv
tb/tb_sorted_release_time_queue.sv
